[rtl/gpvs_pkg.sv]
package gpvs_pkg;

    localparam int MAX_SAMPLES = 1048576;
    localparam int CNT_W = 21;
    localparam int SUM_W = 29;
    localparam int DOS_W = 30;
    localparam int NUM_W = 41;
    localparam int T_W = 30;
    localparam int OPD_W = 64;
    localparam int PRD_W = 2 * OPD_W;
    localparam int MUL_DIG = 16;
    localparam int MUL_STEPS = OPD_W / MUL_DIG;
    localparam int DIV_W = 112;
    localparam int DIVL_W = 64;
    localparam int DIVK_W = 7;
    localparam int OBS_W = 62;
    localparam int AD_W = 63;
    localparam int SQ_W = 126;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] CHI_BASE = 5'd9;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;
    localparam logic [7:0] MISSING_MASK = 8'h80;

    typedef enum logic [3:0] {
        OP_DEN,
        OP_NUMA,
        OP_INFO,
        OP_FREQ,
        OP_OAA,
        OP_OAB,
        OP_OBB,
        OP_EE,
        OP_TT,
        OP_DIFF,
        OP_SQ,
        OP_DD,
        OP_CHI
    } op_t;

    typedef struct packed {
        logic       accum;
        logic       prep;
        logic       start;
        op_t        op;
        logic [1:0] term;
        logic       load;
    } dp_cmd_t;

    typedef struct packed {
        logic degen;
        logic done;
    } dp_stat_t;

    function automatic op_t prog_op(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] rel;
        op_t op;
        rel = step - CHI_BASE;
        op = OP_DEN;
        if (step < CHI_BASE) begin
            unique case (step[3:0])
                4'd0: op = OP_DEN;
                4'd1: op = OP_NUMA;
                4'd2: op = OP_INFO;
                4'd3: op = OP_FREQ;
                4'd4: op = OP_OAA;
                4'd5: op = OP_OAB;
                4'd6: op = OP_OBB;
                4'd7: op = OP_EE;
                4'd8: op = OP_TT;
                default: op = OP_DEN;
            endcase
        end else begin
            unique case (rel[1:0])
                2'd0: op = OP_DIFF;
                2'd1: op = OP_SQ;
                2'd2: op = OP_DD;
                2'd3: op = OP_CHI;
                default: op = OP_DIFF;
            endcase
        end
        return op;
    endfunction

    function automatic logic [1:0] prog_term(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] rel;
        rel = step - CHI_BASE;
        return (step < CHI_BASE) ? 2'd0 : rel[3:2];
    endfunction

endpackage

[rtl/gpvs_mul.sv]
module gpvs_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [gpvs_pkg::OPD_W-1:0]      a,
    input  logic [gpvs_pkg::OPD_W-1:0]      b,
    output logic                            done,
    output logic [gpvs_pkg::PRD_W-1:0]      p
);
    import gpvs_pkg::*;

    logic [OPD_W-1:0]         a_reg;
    logic [OPD_W-1:0]         b_reg;
    logic [PRD_W-1:0]         acc_reg;
    logic [1:0]               cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [OPD_W+MUL_DIG-1:0] pp;
    logic [PRD_W-1:0]         acc_next;

    assign pp = a_reg * b_reg[OPD_W-1 -: MUL_DIG];
    assign acc_next = {acc_reg[PRD_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}} + PRD_W'(pp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[OPD_W-MUL_DIG-1:0], {MUL_DIG{1'b0}}};
        end
    end

    assign done = done_reg;
    assign p = acc_reg;

endmodule

[rtl/gpvs_div.sv]
module gpvs_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [gpvs_pkg::DIV_W-1:0]       h,
    input  logic [gpvs_pkg::DIVL_W-1:0]      l,
    input  logic [gpvs_pkg::DIVK_W-1:0]      k,
    input  logic [gpvs_pkg::DIV_W-1:0]       d,
    output logic                             done,
    output logic                             sat,
    output logic [gpvs_pkg::DIVL_W-1:0]      q
);
    import gpvs_pkg::*;

    logic [DIV_W-1:0]  r_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [DIVL_W-1:0] l_reg;
    logic [DIVL_W-1:0] q_reg;
    logic [DIVK_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [DIV_W:0]    r2;
    logic [DIV_W:0]    r2_sub;
    logic              ge;
    logic              start_sat;

    assign start_sat = (h >= d);
    assign r2 = {r_reg, l_reg[DIVL_W-1]};
    assign ge = (r2 >= {1'b0, d_reg});
    assign r2_sub = r2 - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= k;
                if (start_sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg   <= h;
            d_reg   <= d;
            l_reg   <= l;
            q_reg   <= '0;
            sat_reg <= start_sat;
        end else if (busy_reg) begin
            r_reg <= ge ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];
            l_reg <= {l_reg[DIVL_W-2:0], 1'b0};
            q_reg <= {q_reg[DIVL_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign sat = sat_reg;
    assign q = q_reg;

endmodule

[rtl/gpvs_dp.sv]
module gpvs_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gpvs_pkg::dp_cmd_t             cmd,
    output gpvs_pkg::dp_stat_t            stat,
    input  logic [7:0]                    ploidy_byte,
    input  logic [7:0]                    prob_hom,
    input  logic [7:0]                    prob_het,
    output logic [31:0]                   info_score,
    output logic [16:0]                   allele_freq,
    output logic [31:0]                   hwe_chi_square,
    output logic [gpvs_pkg::CNT_W-1:0]    called_count,
    output logic                          degenerate
);
    import gpvs_pkg::*;

    logic [CNT_W-1:0]        cnt_reg;
    logic [SUM_W-1:0]        sh_reg;
    logic [SUM_W-1:0]        shet_reg;
    logic [DOS_W-1:0]        e_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [T_W-1:0]          t_reg;

    logic [59:0]             den_reg;
    logic [62:0]             numa_reg;
    logic [OBS_W-1:0]        obs0_reg;
    logic [OBS_W-1:0]        obs1_reg;
    logic [OBS_W-1:0]        obs2_reg;
    logic                    obs2_neg_reg;
    logic [OBS_W-1:0]        exp0_reg;
    logic [OBS_W-1:0]        exp2_reg;
    logic [AD_W-1:0]         ad_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIV_W-1:0]        dd_reg;
    logic [31:0]             info_calc_reg;
    logic [16:0]             freq_calc_reg;
    logic [33:0]             sum_reg;
    logic                    diff_done_reg;

    logic [31:0]             out_info_reg;
    logic [16:0]             out_freq_reg;
    logic [31:0]             out_hwe_reg;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic                    out_degen_reg;

    logic                    take;
    logic [9:0]              ed;
    logic [10:0]             fd;
    logic [18:0]             fd255;
    logic [19:0]             ed_sq;
    logic signed [20:0]      contrib;

    logic                    degen;
    logic [T_W-1:0]          te;
    logic [NUM_W-1:0]        mag_num;
    logic [37:0]             off;
    logic [38:0]             d2;
    logic signed [32:0]      xs;
    logic [31:0]             xmag;
    logic [OBS_W-1:0]        exp_sel;
    logic signed [63:0]      obs_s;
    logic signed [63:0]      diff;
    logic [AD_W-1:0]         m_val;

    logic                    is_mul;
    logic                    is_div;
    logic [OPD_W-1:0]        mul_a;
    logic [OPD_W-1:0]        mul_b;
    logic                    mul_done;
    logic [PRD_W-1:0]        mul_p;
    logic [DIV_W-1:0]        div_h;
    logic [DIVL_W-1:0]       div_l;
    logic [DIVK_W-1:0]       div_k;
    logic [DIV_W-1:0]        div_d;
    logic                    div_done;
    logic                    div_sat;
    logic [DIVL_W-1:0]       div_q;

    logic [48:0]             mag;
    logic signed [50:0]      info_val;
    logic [31:0]             info_res;
    logic [32:0]             term;

    localparam logic signed [50:0] INFO_MIN = -51'sd2147483648;

    assign take = cmd.accum && (ploidy_byte < MISSING_MASK) && (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign ed = 10'({prob_hom, 1'b0}) + 10'(prob_het);
    assign fd = 11'({prob_hom, 2'b00}) + 11'(prob_het);
    assign fd255 = 19'({fd, 8'b0}) - 19'(fd);
    assign ed_sq = ed * ed;
    assign contrib = $signed({2'b00, fd255}) - $signed({1'b0, ed_sq});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            sh_reg   <= '0;
            shet_reg <= '0;
            e_reg    <= '0;
            num_reg  <= '0;
            sum_reg  <= '0;
        end else if (cmd.load) begin
            cnt_reg  <= '0;
            sh_reg   <= '0;
            shet_reg <= '0;
            e_reg    <= '0;
            num_reg  <= '0;
            sum_reg  <= '0;
        end else begin
            if (take) begin
                cnt_reg  <= cnt_reg + CNT_W'(1);
                sh_reg   <= sh_reg + SUM_W'(prob_hom);
                shet_reg <= shet_reg + SUM_W'(prob_het);
                e_reg    <= e_reg + DOS_W'(ed);
                num_reg  <= num_reg + {{(NUM_W-21){contrib[20]}}, contrib};
            end
            if (div_done && (cmd.op == OP_CHI)) begin
                sum_reg <= sum_reg + 34'(term);
            end
        end
    end

    assign degen = (cnt_reg == '0) || (e_reg == '0) || (e_reg >= t_reg);
    assign te = t_reg - e_reg;
    assign mag_num = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign off = 38'({t_reg, 8'b0}) - 38'(t_reg);
    assign d2 = {off, 1'b0};
    assign xs = $signed(33'(t_reg)) - $signed(33'({sh_reg, 1'b0}))
              - $signed(33'({shet_reg, 1'b0}));
    assign xmag = xs[32] ? 32'(-xs) : 32'(xs);
    assign m_val = (ad_reg >= AD_W'(off)) ? ad_reg - AD_W'(off) : AD_W'(off) - ad_reg;

    always_comb begin
        unique case (cmd.term)
            2'd0:    exp_sel = exp0_reg;
            2'd1:    exp_sel = {den_reg, 2'b0} >> 1;
            2'd2:    exp_sel = exp2_reg;
            default: exp_sel = exp0_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.term)
            2'd0:    obs_s = $signed({2'b00, obs0_reg});
            2'd1:    obs_s = $signed({2'b00, obs1_reg});
            2'd2:    obs_s = obs2_neg_reg ? -$signed({2'b00, obs2_reg})
                                          : $signed({2'b00, obs2_reg});
            default: obs_s = $signed({2'b00, obs0_reg});
        endcase
    end

    assign diff = obs_s - $signed({2'b00, exp_sel});

    always_comb begin
        is_mul = 1'b1;
        is_div = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (cmd.op)
            OP_DEN: begin
                mul_a = OPD_W'(te);
                mul_b = OPD_W'(e_reg);
            end
            OP_NUMA: begin
                mul_a = OPD_W'(mag_num);
                mul_b = OPD_W'({cnt_reg, 1'b0});
            end
            OP_OAA: begin
                mul_a = OPD_W'(sh_reg);
                mul_b = OPD_W'(t_reg);
            end
            OP_OAB: begin
                mul_a = OPD_W'(shet_reg);
                mul_b = OPD_W'(t_reg);
            end
            OP_OBB: begin
                mul_a = OPD_W'(xmag);
                mul_b = OPD_W'(t_reg);
            end
            OP_EE: begin
                mul_a = OPD_W'(e_reg);
                mul_b = OPD_W'(e_reg);
            end
            OP_TT: begin
                mul_a = OPD_W'(te);
                mul_b = OPD_W'(te);
            end
            OP_SQ: begin
                mul_a = OPD_W'(m_val);
                mul_b = OPD_W'(m_val);
            end
            OP_DD: begin
                mul_a = OPD_W'(exp_sel);
                mul_b = OPD_W'(d2);
            end
            OP_INFO, OP_FREQ, OP_CHI: begin
                is_mul = 1'b0;
                is_div = 1'b1;
            end
            default: begin
                is_mul = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_h = '0;
        div_l = '0;
        div_k = '0;
        div_d = '0;
        unique case (cmd.op)
            OP_INFO: begin
                div_h = DIV_W'(numa_reg[62:32]);
                div_l = {numa_reg[31:0], 32'b0};
                div_k = 7'd49;
                div_d = DIV_W'(den_reg);
            end
            OP_FREQ: begin
                div_h = DIV_W'(te);
                div_k = 7'd17;
                div_d = DIV_W'(t_reg);
            end
            OP_CHI: begin
                div_h = DIV_W'(sq_reg[SQ_W-1:16]);
                div_l = {sq_reg[15:0], 48'b0};
                div_k = 7'd32;
                div_d = dd_reg;
            end
            default: begin
                div_k = '0;
            end
        endcase
    end

    gpvs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && is_mul),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    gpvs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start && is_div),
        .h       (div_h),
        .l       (div_l),
        .k       (div_k),
        .d       (div_d),
        .done    (div_done),
        .sat     (div_sat),
        .q       (div_q)
    );

    assign mag = div_sat ? 49'h1_0000_0000_0000 : 49'((50'(div_q[48:0]) + 50'd1) >> 1);
    assign info_val = $signed(51'd65536) - $signed({2'b00, mag});
    assign info_res = num_reg[NUM_W-1] ? 32'h0001_0000 :
                      (info_val < INFO_MIN) ? 32'h8000_0000 : info_val[31:0];
    assign term = div_sat ? 33'h1_0000_0000 : {1'b0, div_q[31:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_done_reg <= 1'b0;
        end else begin
            diff_done_reg <= cmd.start && (cmd.op == OP_DIFF);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            t_reg <= T_W'({cnt_reg, 9'b0}) - T_W'({cnt_reg, 1'b0});
        end
        if (cmd.start && (cmd.op == OP_DIFF)) begin
            ad_reg <= diff[63] ? AD_W'(-diff) : AD_W'(diff);
        end
        if (mul_done) begin
            unique case (cmd.op)
                OP_DEN:  den_reg  <= mul_p[59:0];
                OP_NUMA: numa_reg <= mul_p[62:0];
                OP_OAA:  obs0_reg <= {mul_p[60:0], 1'b0};
                OP_OAB:  obs1_reg <= {mul_p[60:0], 1'b0};
                OP_OBB: begin
                    obs2_reg     <= mul_p[OBS_W-1:0];
                    obs2_neg_reg <= xs[32];
                end
                OP_EE:   exp0_reg <= mul_p[OBS_W-1:0];
                OP_TT:   exp2_reg <= mul_p[OBS_W-1:0];
                OP_SQ:   sq_reg   <= mul_p[SQ_W-1:0];
                OP_DD:   dd_reg   <= mul_p[DIV_W-1:0];
                default: sq_reg   <= sq_reg;
            endcase
        end
        if (div_done && (cmd.op == OP_INFO)) begin
            info_calc_reg <= info_res;
        end
        if (div_done && (cmd.op == OP_FREQ)) begin
            freq_calc_reg <= 17'((18'(div_q[16:0]) + 18'd1) >> 1);
        end
        if (cmd.load) begin
            out_cnt_reg   <= cnt_reg;
            out_degen_reg <= degen;
            out_info_reg  <= degen ? '0 : info_calc_reg;
            out_freq_reg  <= degen ? '0 : freq_calc_reg;
            out_hwe_reg   <= degen ? '0 : ((sum_reg[33:32] != 2'b00) ? 32'hFFFF_FFFF
                                                                 : sum_reg[31:0]);
        end
    end

    assign stat.degen = degen;
    assign stat.done = mul_done || div_done || diff_done_reg;

    assign info_score = out_info_reg;
    assign allele_freq = out_freq_reg;
    assign hwe_chi_square = out_hwe_reg;
    assign called_count = out_cnt_reg;
    assign degenerate = out_degen_reg;

endmodule

[rtl/gpvs_ctrl.sv]
module gpvs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  gpvs_pkg::dp_stat_t  stat,
    output gpvs_pkg::dp_cmd_t   cmd
);
    import gpvs_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_PREP,
        S_CHECK,
        S_ISSUE,
        S_WAIT,
        S_HOLD
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              m_tvalid_reg;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_ACC);

    always_comb begin
        cmd.accum = s_tvalid && (state_reg == S_ACC);
        cmd.prep  = (state_reg == S_PREP);
        cmd.start = (state_reg == S_ISSUE);
        cmd.op    = prog_op(step_reg);
        cmd.term  = prog_term(step_reg);
        cmd.load  = (state_reg == S_HOLD) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_ACC;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_ACC: begin
                    if (s_tvalid && s_tlast) begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    step_reg <= '0;
                    state_reg <= stat.degen ? S_HOLD : S_ISSUE;
                end
                S_ISSUE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (stat.done) begin
                        if (step_reg == LAST_STEP) begin
                            state_reg <= S_HOLD;
                        end else begin
                            step_reg  <= step_reg + STEP_W'(1);
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        state_reg <= S_ACC;
                    end
                end
                default: begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/genotype_probability_variant_stats.sv]
// Per-variant genotype statistics: INFO score, allele frequency and HWE chi-square.
// The slave channel takes one sample request per cycle while s_tready is high;
// tdata carries the ploidy byte, the homozygous and the heterozygous probability,
// and tlast closes the variant. Samples whose ploidy byte has its top bit set
// count as missing. Each accepted sample is accumulated as it is taken. The request
// with tlast starts the end-of-variant computation, during which s_tready is low;
// it runs through a shared 64x16 serial multiplier and a one-bit-per-cycle divider,
// and m_tvalid rises once the last step is done, sooner when a quotient overflows and
// is saturated, or just after the prepare and check states for a degenerate variant.
// The master channel then carries one result request: INFO score, frequency,
// chi-square and sample count in tdata, and the degenerate flag in tuser.
// The result sits in an output register; a stalled receiver holds it, and the block
// keeps taking samples of the next variant meanwhile. The next variant's result
// waits in the controller until the output register is free.
// A synchronous active-low reset clears the accumulators and drops m_tvalid.
module genotype_probability_variant_stats (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ploidy_byte [7:0], prob_hom [15:8], prob_het [23:16]
    input  logic [23:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // info_score [31:0], allele_freq [48:32], hwe_chi_square [80:49],
    // called_count [101:81], zero fill [103:102]
    output logic [103:0] m_tdata,
    // degenerate [0]
    output logic         m_tuser
);
    import gpvs_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [31:0]      info_score;
    logic [16:0]      allele_freq;
    logic [31:0]      hwe_chi_square;
    logic [CNT_W-1:0] called_count;
    logic             degenerate;

    gpvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gpvs_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .ploidy_byte    (s_tdata[7:0]),
        .prob_hom       (s_tdata[15:8]),
        .prob_het       (s_tdata[23:16]),
        .info_score     (info_score),
        .allele_freq    (allele_freq),
        .hwe_chi_square (hwe_chi_square),
        .called_count   (called_count),
        .degenerate     (degenerate)
    );

    assign m_tdata = {2'b00, called_count, hwe_chi_square, allele_freq, info_score};
    assign m_tuser = degenerate;

endmodule
